[hdl/pac_pkg.sv]
`default_nettype none
package pac_pkg;

	// fixed field widths
	localparam int COORD_WIDTH = 16;
	localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
	localparam int SUM_WIDTH   = 45;
	localparam int AREA_WIDTH  = 44;
	localparam int TOTAL_WIDTH = 13;

	// default configuration
	localparam int MAX_POINTS_DEF  = 4096;
	localparam int QUEUE_DEPTH_DEF = 4;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_MANY = 2'd2
	} pac_status_t;

	// one classified vertex, handed from front to back
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] prev_x;
		logic signed [COORD_WIDTH-1:0] prev_y;
		logic signed [COORD_WIDTH-1:0] first_x;
		logic signed [COORD_WIDTH-1:0] first_y;
		logic                          last;
		pac_status_t                   status;
		logic [TOTAL_WIDTH-1:0]        total;
	} pac_job_t;

endpackage
`default_nettype wire

[hdl/pac_front.sv]
`default_nettype none
module pac_front
	import pac_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] x_coord,
	input  wire logic signed [COORD_WIDTH-1:0] y_coord,
	input  wire logic                          final_vertex,
	output logic                               job_valid,
	input  wire logic                          job_ready,
	output pac_job_t                           job
);

	localparam int CNT_W = $clog2(MAX_POINTS + 2);
	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_POINTS + 1);
	localparam logic [CNT_W-1:0] MAXP  = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0] TWO   = CNT_W'(2);

	logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              total;
	logic [CNT_W+TOTAL_WIDTH-1:0]  total_wide;
	logic                          accept;
	logic                          is_first;
	pac_status_t                   status;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign accept    = in_valid && in_ready;
	assign is_first  = (count_q == '0);

	// saturating vertex count and status classification
	always_comb begin
		total  = (count_q >= LIMIT) ? LIMIT : count_q + CNT_W'(1);
		status = ST_OK;
		if (total < TWO) begin
			status = ST_FEW;
		end else if (total > MAXP) begin
			status = ST_MANY;
		end
	end

	assign total_wide = {{TOTAL_WIDTH{1'b0}}, total};

	// job for the back end; closing operands only on the last vertex
	always_comb begin
		job.x       = x_coord;
		job.y       = y_coord;
		job.prev_x  = prev_x_q;
		job.prev_y  = prev_y_q;
		job.first_x = '0;
		job.first_y = '0;
		if (final_vertex) begin
			job.first_x = is_first ? x_coord : first_x_q;
			job.first_y = is_first ? y_coord : first_y_q;
		end
		job.last   = final_vertex;
		job.status = status;
		job.total  = total_wide[TOTAL_WIDTH-1:0];
	end

	// polygon tracking state, cleared after the last vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (final_vertex) begin
				first_x_q <= '0;
				first_y_q <= '0;
				prev_x_q  <= '0;
				prev_y_q  <= '0;
				count_q   <= '0;
			end else begin
				if (is_first) begin
					first_x_q <= x_coord;
					first_y_q <= y_coord;
				end
				prev_x_q <= x_coord;
				prev_y_q <= y_coord;
				count_q  <= total;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/pac_queue.sv]
`default_nettype none
module pac_queue
	import pac_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_valid,
	output logic          wr_ready,
	input  wire pac_job_t wr_data,
	output logic          rd_valid,
	input  wire logic     rd_ready,
	output pac_job_t      rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pac_job_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push, pop;

	assign wr_ready = (fill_q != CNT_W'(DEPTH));
	assign rd_valid = (fill_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/pac_back.sv]
`default_nettype none
module pac_back
	import pac_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	output logic                    job_ready,
	input  wire pac_job_t           job,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [AREA_WIDTH-1:0]   doubled_area,
	output logic [1:0]              status,
	output logic [TOTAL_WIDTH-1:0]  vertex_total
);

	// stage 1: cross products
	logic                         valid_s1;
	logic signed [PROD_WIDTH-1:0] p_step_a_s1, p_step_b_s1, p_close_a_s1, p_close_b_s1;
	logic                         last_s1;
	pac_status_t                  status_s1;
	logic [TOTAL_WIDTH-1:0]       total_s1;

	// stage 2: finished sum of one polygon
	logic                         valid_s2;
	logic signed [SUM_WIDTH-1:0]  sum_s2;
	pac_status_t                  status_s2;
	logic [TOTAL_WIDTH-1:0]       total_s2;

	// running sum and output register
	logic signed [SUM_WIDTH-1:0]  sum_q;
	logic signed [SUM_WIDTH-1:0]  sum_next;
	logic                         out_valid_q;
	logic [AREA_WIDTH-1:0]        area_q;
	pac_status_t                  status_q;
	logic [TOTAL_WIDTH-1:0]       total_q;
	logic [SUM_WIDTH-1:0]         neg_sum;
	logic [AREA_WIDTH-1:0]        mag;

	logic out_load, s2_free, s1_move, s1_load;

	// stall control
	assign out_load  = valid_s2 && (!out_valid_q || out_ready);
	assign s2_free   = !valid_s2 || out_load;
	assign s1_move   = valid_s1 && (!last_s1 || s2_free);
	assign s1_load   = job_valid && job_ready;
	assign job_ready = !valid_s1 || s1_move;

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (job_ready) begin
			valid_s1 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			p_step_a_s1  <= job.prev_x * job.y;
			p_step_b_s1  <= job.x * job.prev_y;
			p_close_a_s1 <= job.x * job.first_y;
			p_close_b_s1 <= job.first_x * job.y;
			last_s1      <= job.last;
			status_s1    <= job.status;
			total_s1     <= job.total;
		end
	end

	// accumulate edge and closing terms
	assign sum_next = sum_q
		+ SUM_WIDTH'(p_step_a_s1) - SUM_WIDTH'(p_step_b_s1)
		+ SUM_WIDTH'(p_close_a_s1) - SUM_WIDTH'(p_close_b_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_move) begin
				sum_q <= last_s1 ? '0 : sum_next;
			end
			if (s1_move && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_load) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			sum_s2    <= sum_next;
			status_s2 <= status_s1;
			total_s2  <= total_s1;
		end
	end

	// magnitude of the sum, zero unless status is ok
	always_comb begin
		neg_sum = ~sum_s2 + SUM_WIDTH'(1);
		mag     = sum_s2[SUM_WIDTH-1] ? neg_sum[AREA_WIDTH-1:0] : sum_s2[AREA_WIDTH-1:0];
		if (status_s2 != ST_OK) begin
			mag = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			area_q   <= mag;
			status_q <= status_s2;
			total_q  <= total_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign doubled_area = area_q;
	assign status       = status_q;
	assign vertex_total = total_q;

endmodule
`default_nettype wire

[hdl/polygon_area_accumulator_core.sv]
// path: queue, stage 1 products, stage 2 sum and output register; throughput is one
// vertex per cycle unless stalled, set by the single product stage and accumulator
// the queue between front and back holds QUEUE_DEPTH vertices, so input stalls
// only when the queue is full, which needs stage 2 and the result register full
// reset: arst_n clears all polygon state, the running sum and all valid flags
`default_nettype none
module polygon_area_accumulator_core
	import pac_pkg::*;
#(
	parameter int MAX_POINTS  = MAX_POINTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] x_coord,
	input  wire logic signed [COORD_WIDTH-1:0] y_coord,
	input  wire logic                          final_vertex,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [AREA_WIDTH-1:0]              doubled_area,
	output logic [1:0]                         status,
	output logic [TOTAL_WIDTH-1:0]             vertex_total
);

	pac_job_t front_job, back_job;
	logic     front_valid, front_ready, back_valid, back_ready;

	// vertex tracking and classification
	pac_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.final_vertex (final_vertex),
		.job_valid    (front_valid),
		.job_ready    (front_ready),
		.job          (front_job)
	);

	// decoupling queue
	pac_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_data  (front_job),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_data  (back_job)
	);

	// products, accumulation and result
	pac_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (back_valid),
		.job_ready    (back_ready),
		.job          (back_job),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.doubled_area (doubled_area),
		.status       (status),
		.vertex_total (vertex_total)
	);

endmodule
`default_nettype wire
